[hw/rtl/ultrasonic_echo_ranger_defines.svh]
// assertion macros for the ranger rtl
// both expect aclk and aresetn in the scope where they are used
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// same-cycle implication
`define UER_ASSERT_HOLD(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("ranger check failed");

// next-cycle implication
`define UER_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("ranger check failed");

`endif

[hw/rtl/uer_pkg.sv]
`default_nettype none

package uer_pkg;

    localparam int SPD_W = 19;
    localparam int TEMP_W = 11;

    localparam logic signed [TEMP_W-1:0] TEMP_RESET = 11'sd200;

    // controller to datapath commands
    typedef struct packed {
        logic root_load;
        logic root_step;
        logic mul_load;
        logic div_load;
    } calc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic temp_changed;
        logic root_last;
    } calc_stat_t;

    // per-beat outcome of the measurement sequencer
    typedef struct packed {
        logic        trig;
        logic        busy;
        logic        done;
        logic        found;
        logic [15:0] pulse;
        logic        need_dist;
    } meas_res_t;

endpackage

`default_nettype wire

[hw/rtl/ultrasonic_echo_ranger.sv]
// channel | dir | fields (lowest bit up)
// --------+-----+-------------------------------------------------------------
// cfg     | in  | cfg_index: 0 temperature_deci_c, 1 echo_timeout_us,
//         |     |   2 trigger_width_us; cfg_data low bits carry the value
// s_      | in  | tuser: func[1:0]; tdata: echo_level, time_us[15:0], pad
// m_      | out | tuser: done_res, echo_found;
//         |     | tdata: trigger_level, busy_res, pulse_us[15:0],
//         |     |   distance_um[23:0], pad
//
// one input beat in flight at a time; a beat with no distance to work out
// goes through accept, decode and result load, which waits for a free output
// a beat that ends a measurement or asks for a conversion also goes through
// speed times time, then a reciprocal multiply for the divide by 2000
// a changed temperature adds the speed square root first (19 steps)
// the result register lets the next beat in while the last result waits;
// aresetn is synchronous; no clearing pass, ready as soon as reset is released
`default_nettype none
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger #(
    parameter int TIME_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    // tick / request beats
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // echo_level, time_us[15:0], pad
    input  wire logic [1:0]   s_tuser,   // func[1:0]
    // result beats
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // trigger_level, busy_res, pulse_us, distance_um, pad
    output logic [1:0]        m_tuser    // done_res, echo_found
);
    import uer_pkg::*;

    localparam int T_W = (TIME_BITS > 16) ? TIME_BITS : 16;

    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_TRIGW   = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd11661;
    localparam logic [7:0]  TRIGW_RESET   = 8'd12;

    // configuration registers
    logic signed [TEMP_W-1:0] temp_reg;
    logic [15:0]              timeout_reg;
    logic [7:0]               trigw_reg;

    // result register
    logic                     m_tvalid_reg;
    logic [47:0]              m_tdata_reg;
    logic [1:0]               m_tuser_reg;

    // controller / datapath links
    logic                     step_en;
    logic                     emit;
    logic                     out_free;
    meas_res_t                meas_res;
    logic [T_W-1:0]           t_op;
    calc_cmd_t                cmd;
    calc_stat_t               stat;
    logic [23:0]              dist_um;
    logic [23:0]              dist_sel;

    // registers are to be written only while the block is idle (the user's rule, not enforced), so always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg    <= TEMP_RESET;
            timeout_reg <= TIMEOUT_RESET;
            trigw_reg   <= TRIGW_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TEMP:    temp_reg    <= cfg_data[TEMP_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_TRIGW:   trigw_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer: handshake and the order of datapath steps
    uer_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .step_en   (step_en),
        .need_dist (meas_res.need_dist),
        .out_free  (out_free),
        .emit      (emit),
        .cmd       (cmd),
        .stat      (stat)
    );

    // trigger, echo wait and width count, one step per accepted beat
    uer_meas #(
        .TIME_BITS (TIME_BITS),
        .T_W       (T_W)
    ) u_meas (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .func       (s_tuser),
        .echo_level (s_tdata[0]),
        .time_us    (s_tdata[16:1]),
        .timeout    (timeout_reg),
        .trig_width (trigw_reg),
        .res        (meas_res),
        .t_op       (t_op)
    );

    // sound speed root, speed times time, divide by 2000
    uer_calc #(
        .TIME_BITS (TIME_BITS),
        .T_W       (T_W)
    ) u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .temp    (temp_reg),
        .t_op    (t_op),
        .dist_um (dist_um)
    );

    // distance only goes out with a finished measurement or conversion
    assign dist_sel = meas_res.need_dist ? dist_um : 24'd0;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {6'd0, dist_sel, meas_res.pulse, meas_res.busy, meas_res.trig};
            m_tuser_reg <= {meas_res.found, meas_res.done};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // one beat at a time: an accepted beat closes the input until its result is out
    `UER_ASSERT_NEXT(a_one_beat, s_tvalid && s_tready, !s_tready)
    // trigger high only before any wait can end
    `UER_ASSERT_HOLD(a_trig_not_done, m_tvalid && m_tdata[0], !m_tuser[0])
    // a finished beat always leaves the sequencer idle
    `UER_ASSERT_HOLD(a_done_not_busy, m_tvalid && m_tuser[0], !m_tdata[1])
    // a distance or width only comes with a finished beat
    `UER_ASSERT_HOLD(a_dist_done, m_tvalid && (m_tdata[41:2] != 40'd0), m_tuser[0])

endmodule

`default_nettype wire

[hw/rtl/uer_meas.sv]
`default_nettype none

module uer_meas #(
    parameter int TIME_BITS = 16,
    parameter int T_W = (TIME_BITS > 16) ? TIME_BITS : 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire logic [1:0]       func,
    input  wire logic             echo_level,
    input  wire logic [15:0]      time_us,
    input  wire logic [15:0]      timeout,
    input  wire logic [7:0]       trig_width,
    output uer_pkg::meas_res_t    res,
    output logic      [T_W-1:0]   t_op
);
    import uer_pkg::*;

    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_CONV  = 2'd2;
    localparam logic [TIME_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_TRIG      = 5'b00010,
        PH_WAIT_LOW  = 5'b00100,
        PH_WAIT_RISE = 5'b01000,
        PH_MEASURE   = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [TIME_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]   width_reg, width_next;
    meas_res_t              res_reg, res_next;
    logic [T_W-1:0]         t_op_reg, t_op_next;

    logic [TIME_BITS-1:0]   tw_ext;
    logic [T_W-1:0]         width_ext;
    phase_t                 ph;
    logic [TIME_BITS-1:0]   el;

    assign tw_ext    = (trig_width == 8'd0) ? TIME_BITS'(1) : TIME_BITS'(trig_width);
    assign width_ext = T_W'(width_reg);

    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        width_next   = width_reg;
        t_op_next    = t_op_reg;
        res_next     = '0;
        ph           = phase_reg;
        el           = elapsed_reg;
        if (phase_reg == PH_IDLE) begin
            if (func == FUNC_START) begin
                phase_next    = PH_TRIG;
                elapsed_next  = TIME_BITS'(1);
                width_next    = '0;
                res_next.trig = 1'b1;
            end else if (func == FUNC_CONV) begin
                res_next.done      = 1'b1;
                res_next.found     = |time_us;
                res_next.pulse     = time_us;
                res_next.need_dist = 1'b1;
                t_op_next          = T_W'(time_us);
            end
        end else if (phase_reg == PH_TRIG && elapsed_reg < tw_ext) begin
            res_next.trig = 1'b1;
            elapsed_next  = elapsed_reg + TIME_BITS'(1);
        end else begin
            if (phase_reg == PH_TRIG) begin
                ph = PH_WAIT_LOW;
                el = '0;
            end
            if (el != CNT_MAX) begin
                el = el + TIME_BITS'(1);
            end
            unique case (ph)
                PH_WAIT_LOW: begin
                    if (!echo_level) begin
                        ph = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE: begin
                    if (echo_level) begin
                        ph         = PH_MEASURE;
                        width_next = TIME_BITS'(1);
                    end
                end
                PH_MEASURE: begin
                    if (echo_level) begin
                        if (width_reg != CNT_MAX) begin
                            width_next = width_reg + TIME_BITS'(1);
                        end
                    end else begin
                        res_next.done      = 1'b1;
                        res_next.found     = 1'b1;
                        res_next.pulse     = (width_ext > T_W'(16'hFFFF)) ? 16'hFFFF
                                                                          : 16'(width_ext);
                        res_next.need_dist = 1'b1;
                        t_op_next          = width_ext;
                        ph                 = PH_IDLE;
                    end
                end
                default: begin
                    ph = PH_IDLE;
                end
            endcase
            // timeout, unless an echo just finished
            if (!res_next.done && (T_W'(el) >= T_W'(timeout) || el == CNT_MAX)) begin
                res_next.done = 1'b1;
                ph            = PH_IDLE;
            end
            phase_next   = ph;
            elapsed_next = el;
        end
        res_next.busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            width_reg   <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            width_reg   <= width_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg  <= res_next;
            t_op_reg <= t_op_next;
        end
    end

    assign res  = res_reg;
    assign t_op = t_op_reg;

endmodule

`default_nettype wire

[hw/rtl/uer_calc.sv]
`default_nettype none

module uer_calc #(
    parameter int TIME_BITS = 16,
    parameter int T_W = (TIME_BITS > 16) ? TIME_BITS : 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  uer_pkg::calc_cmd_t                       cmd,
    output uer_pkg::calc_stat_t                      stat,
    input  wire logic signed [uer_pkg::TEMP_W-1:0]   temp,
    input  wire logic        [T_W-1:0]               t_op,
    output logic             [23:0]                  dist_um
);
    import uer_pkg::*;

    localparam int RAD_W     = 38;
    localparam int ROOT_TOP  = 36;
    localparam int QUO_W     = 24;
    localparam int DIV_K     = 2000;
    localparam int PROD_W    = SPD_W + T_W;
    // divide by 2000 as a drop of 4 bits, then times 2^38/125 rounded up
    localparam int REC_IN_LO = 4;
    localparam int REC_IN_W  = 31;
    localparam int REC_SH    = 38;
    localparam int REC_W     = REC_SH + QUO_W;

    localparam logic [24:0]        RAD_K     = 25'd20093500;
    localparam logic [13:0]        RAD_OFS   = 14'd5463;
    localparam logic [SPD_W-1:0]   SPD_RESET = 19'd343000;
    localparam logic [RAD_W-1:0]   BIT_TOP   = RAD_W'(64'd1 << ROOT_TOP);
    localparam logic [PROD_W-1:0]  PROD_LIM  = PROD_W'(64'(DIV_K) << QUO_W);
    localparam logic [31:0]        REC_M     = 32'd2199023256;
    localparam logic [QUO_W-1:0]   DIST_MAX  = '1;

    logic [SPD_W-1:0]            speed_reg;
    logic signed [TEMP_W-1:0]    last_temp_reg;
    logic [RAD_W-1:0]            rad_reg, root_reg, bit_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic                        sat_reg;
    logic [REC_W-1:0]            rec_reg;

    logic [13:0]                 ofs;
    logic [RAD_W-1:0]            root_sum, root_next;
    logic                        root_ge;

    // 5463 + 2*T, always positive over the whole 11-bit range
    assign ofs       = RAD_OFS + {{2{temp[TEMP_W-1]}}, temp, 1'b0};
    assign root_sum  = root_reg + bit_reg;
    assign root_ge   = (rad_reg >= root_sum);
    assign root_next = root_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg     <= SPD_RESET;
            last_temp_reg <= TEMP_RESET;
        end else if (cmd.root_step && bit_reg[0]) begin
            speed_reg     <= root_next[SPD_W-1:0];
            last_temp_reg <= temp;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.root_load) begin
            rad_reg  <= RAD_W'(RAD_K) * RAD_W'(ofs[12:0]);
            root_reg <= '0;
            bit_reg  <= BIT_TOP;
        end else if (cmd.root_step) begin
            if (root_ge) begin
                rad_reg <= rad_reg - root_sum;
            end
            root_reg <= root_next;
            bit_reg  <= bit_reg >> 2;
        end
        if (cmd.mul_load) begin
            prod_reg <= PROD_W'(speed_reg) * PROD_W'(t_op);
        end
        // below the limit the product fits 35 bits and the quotient 24 bits
        if (cmd.div_load) begin
            sat_reg <= (prod_reg >= PROD_LIM);
            rec_reg <= REC_W'(prod_reg[REC_IN_LO+REC_IN_W-1:REC_IN_LO]) * REC_W'(REC_M);
        end
    end

    assign stat.temp_changed = (temp != last_temp_reg);
    assign stat.root_last    = bit_reg[0];
    assign dist_um           = sat_reg ? DIST_MAX : rec_reg[REC_W-1:REC_SH];

endmodule

`default_nettype wire

[hw/rtl/uer_ctrl.sv]
`default_nettype none

module uer_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                step_en,
    input  wire logic           need_dist,
    input  wire logic           out_free,
    output logic                emit,
    output uer_pkg::calc_cmd_t  cmd,
    input  uer_pkg::calc_stat_t stat
);
    import uer_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b000_0001,
        ST_CHECK     = 7'b000_0010,
        ST_ROOT_LOAD = 7'b000_0100,
        ST_ROOT      = 7'b000_1000,
        ST_MUL       = 7'b001_0000,
        ST_DIV_LOAD  = 7'b010_0000,
        ST_EMIT      = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!need_dist) begin
                    state_next = ST_EMIT;
                end else if (stat.temp_changed) begin
                    state_next = ST_ROOT_LOAD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_ROOT_LOAD: state_next = ST_ROOT;
            ST_ROOT: begin
                if (stat.root_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:      state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign step_en       = in_valid && (state_reg == ST_IDLE);
    assign emit          = out_free && (state_reg == ST_EMIT);
    assign cmd.root_load = (state_reg == ST_ROOT_LOAD);
    assign cmd.root_step = (state_reg == ST_ROOT);
    assign cmd.mul_load  = (state_reg == ST_MUL);
    assign cmd.div_load  = (state_reg == ST_DIV_LOAD);

endmodule

`default_nettype wire
